FILE: rtl/core/rtlfo_pkg.sv
// shared types, constants and functions of the random target lfo
`default_nettype none

package rtlfo_pkg;

    localparam int LEVEL_BITS  = 24;
    localparam int INTERP_BITS = 24;
    localparam int BLOCK_BITS  = 16;
    localparam int REG_BITS    = 32;
    localparam int PRE_SHIFT   = 8;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [REG_BITS-1:0] SEED_DEFAULT = 32'h9E37_79B9;
    localparam logic [REG_BITS-1:0] PERIOD_MIN   = 32'd256;
    localparam logic [REG_BITS-1:0] PERIOD_RESET = 32'd122_880_000;
    localparam logic [REG_BITS-1:0] SEED_RESET   = 32'd0;

    typedef logic signed [LEVEL_BITS-1:0] level_t;

    typedef enum logic [1:0]
    {
        CMD_PROCESS = 2'd0,
        CMD_SYNC    = 2'd1,
        CMD_LOAD    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_PERIOD = 1'd0,
        REG_SEED   = 1'd1
    } reg_idx_t;

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [REG_BITS-1:0] xorshift32(input logic [REG_BITS-1:0] x);
        logic [REG_BITS-1:0] v;
        v = x;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // top bits of the generator word with the sign bit flipped
    function automatic level_t word_to_level(input logic [REG_BITS-1:0] x);
        return level_t'({~x[REG_BITS-1], x[REG_BITS-2:REG_BITS-LEVEL_BITS]});
    endfunction

    localparam logic [REG_BITS-1:0] RNG_RESET    = xorshift32(SEED_DEFAULT);
    localparam level_t              TARGET_RESET = word_to_level(RNG_RESET);

endpackage

`default_nettype wire

FILE: rtl/core/rtlfo_if.sv
// valid/ready channels for lfo commands and lfo results
`default_nettype none

interface rtlfo_in_if import rtlfo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [BLOCK_BITS-1:0] step_len;
    level_t                end_cur;
    level_t                end_next;

    modport source (output valid, output cmd, output step_len, output end_cur,
                    output end_next, input ready);
    modport sink (input valid, input cmd, input step_len, input end_cur,
                  input end_next, output ready);
endinterface

interface rtlfo_out_if import rtlfo_pkg::*; ();
    logic   valid;
    logic   ready;
    level_t level;
    logic   new_target;

    modport source (output valid, output level, output new_target, input ready);
    modport sink (input valid, input level, input new_target, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/random_target_lfo_core.sv
// random target lfo: xorshift32 targets with linear interpolation over a divided phase
//
// usage
// - cfg port: cfg_we with cfg_index/cfg_data writes period_q8 (index 0) or seed (index 1);
//   write only while the block is idle
// - in_ch takes one command per transfer: process block, sync, load endpoints, restart
// - out_ch gives one result (level, new_target) per process command, none for others
// timing
// - sync, load and restart act at the transfer; in_ch stays ready for the next transfer
// - process keeps in_ch not ready until its finish state has loaded the result
//   into the output register
// - a process command first runs the restoring divider that forms the phase increment,
//   one quotient bit per cycle over PHASE_BITS+24 bits, then phase update,
//   multiply and add
// reset
// - registers reset to period 122880000 and seed 0, generator state to the
//   default seed advanced once with its first draw as target
// stall
// - a finished result waits in the output register; a later process command is
//   computed meanwhile and holds in its finish state until the output register frees
`default_nettype none

module random_target_lfo_core
    import rtlfo_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [REG_BITS-1:0]       cfg_data,
    rtlfo_in_if.sink                       in_ch,
    rtlfo_out_if.source                    out_ch
);

    localparam int DIV_STEPS = PHASE_BITS + BLOCK_BITS + PRE_SHIFT;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);
    localparam int PROD_BITS = LEVEL_BITS + INTERP_BITS + 2;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_PHASE,
        ST_MUL,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [REG_BITS-1:0] period_reg;
    logic [REG_BITS-1:0] seed_reg;

    // lfo state
    state_t                state_reg;
    logic [REG_BITS-1:0]   rng_reg;
    level_t                start_reg;
    level_t                target_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    level_t                last_reg;
    logic                  sync_pending_reg;

    // divider and datapath registers
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [BLOCK_BITS-1:0] dvd_reg;
    logic [REG_BITS-1:0]   rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic                  ovf_reg;
    logic                  nt_reg;
    logic signed [PROD_BITS-1:0] prod_reg;

    // output register
    logic   out_valid_reg;
    level_t out_level_reg;
    logic   out_nt_reg;

    // combinational values
    logic [REG_BITS-1:0]   p_eff;
    logic [REG_BITS:0]     trial;
    logic                  trial_ge;
    logic [REG_BITS:0]     trial_sub;
    logic [REG_BITS-1:0]   rng_next;
    logic [REG_BITS-1:0]   seed_word;
    logic [REG_BITS-1:0]   restart_next;
    logic [PHASE_BITS:0]   phase_sum;
    logic                  wrap;
    logic [PHASE_BITS+INTERP_BITS-1:0] phase_ext;
    logic [INTERP_BITS-1:0] frac;
    logic signed [LEVEL_BITS:0]  diff;
    logic signed [INTERP_BITS:0] frac_s;
    logic signed [PROD_BITS-1:0] prod_shift;
    logic [LEVEL_BITS:0]   level_wide;
    level_t                level_calc;
    logic                  in_xfer;
    logic                  out_free;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign in_xfer           = in_ch.valid && in_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.level      = out_level_reg;
    assign out_ch.new_target = out_nt_reg;
    assign out_free          = !out_valid_reg || out_ch.ready;

    // period below one sample counts as one sample
    assign p_eff = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;

    // one restoring division step: bring down the next dividend bit
    assign trial     = {rem_reg, dvd_reg[BLOCK_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, p_eff});
    assign trial_sub = trial - {1'b0, p_eff};

    assign rng_next     = xorshift32(rng_reg);
    assign seed_word    = (seed_reg == '0) ? SEED_DEFAULT : seed_reg;
    assign restart_next = xorshift32(seed_word);

    // any quotient bit above the phase width, or a carry, means a wrap
    assign phase_sum = {1'b0, phase_reg} + {1'b0, quo_reg};
    assign wrap      = phase_sum[PHASE_BITS] || ovf_reg;

    // top interpolation bits of the phase, zero filled for a short phase
    assign phase_ext = {phase_reg, {INTERP_BITS{1'b0}}};
    assign frac      = phase_ext[PHASE_BITS+INTERP_BITS-1 -: INTERP_BITS];
    assign diff      = {target_reg[LEVEL_BITS-1], target_reg}
                     - {start_reg[LEVEL_BITS-1], start_reg};
    assign frac_s    = {1'b0, frac};

    // floor of the scaled difference added to the start endpoint
    assign prod_shift = prod_reg >>> INTERP_BITS;
    assign level_wide = {start_reg[LEVEL_BITS-1], start_reg} + prod_shift[LEVEL_BITS:0];
    assign level_calc = level_t'(level_wide[LEVEL_BITS-1:0]);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            seed_reg   <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PERIOD: period_reg <= cfg_data;
                REG_SEED:   seed_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer, lfo state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rng_reg          <= RNG_RESET;
            start_reg        <= '0;
            target_reg       <= TARGET_RESET;
            phase_reg        <= '0;
            last_reg         <= '0;
            sync_pending_reg <= 1'b0;
            cnt_reg          <= '0;
            dvd_reg          <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            ovf_reg          <= 1'b0;
            nt_reg           <= 1'b0;
            prod_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_level_reg    <= '0;
            out_nt_reg       <= 1'b0;
        end
        else
        begin
            // the finish step loads the output register itself
            if (out_valid_reg && out_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (cmd_t'(in_ch.cmd))
                            CMD_PROCESS:
                            begin
                                nt_reg           <= sync_pending_reg;
                                sync_pending_reg <= 1'b0;
                                dvd_reg          <= in_ch.step_len;
                                rem_reg          <= '0;
                                quo_reg          <= '0;
                                ovf_reg          <= 1'b0;
                                cnt_reg          <= '0;
                                state_reg        <= ST_DIV;
                            end
                            CMD_SYNC:
                            begin
                                start_reg        <= last_reg;
                                rng_reg          <= rng_next;
                                target_reg       <= word_to_level(rng_next);
                                phase_reg        <= '0;
                                sync_pending_reg <= 1'b1;
                            end
                            CMD_LOAD:
                            begin
                                start_reg  <= in_ch.end_cur;
                                last_reg   <= in_ch.end_cur;
                                target_reg <= in_ch.end_next;
                                phase_reg  <= '0;
                            end
                            CMD_RESTART:
                            begin
                                rng_reg          <= restart_next;
                                start_reg        <= '0;
                                target_reg       <= word_to_level(restart_next);
                                phase_reg        <= '0;
                                last_reg         <= '0;
                                sync_pending_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_DIV:
                begin
                    dvd_reg <= {dvd_reg[BLOCK_BITS-2:0], 1'b0};
                    rem_reg <= trial_ge ? trial_sub[REG_BITS-1:0] : trial[REG_BITS-1:0];
                    quo_reg <= {quo_reg[PHASE_BITS-2:0], trial_ge};
                    ovf_reg <= ovf_reg || quo_reg[PHASE_BITS-1];
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_PHASE;
                    end
                end

                ST_PHASE:
                begin
                    phase_reg <= phase_sum[PHASE_BITS-1:0];
                    if (wrap)
                    begin
                        start_reg  <= target_reg;
                        rng_reg    <= rng_next;
                        target_reg <= word_to_level(rng_next);
                        nt_reg     <= 1'b1;
                    end
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    prod_reg  <= diff * frac_s;
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        last_reg      <= level_calc;
                        out_level_reg <= level_calc;
                        out_nt_reg    <= nt_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a result appears only from the last step of a process command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    // the generator word can never become zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rng_reg != '0)
        else $error("generator word is zero");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < p_eff))
        else $error("divider remainder out of range");

    // commands other than process leave the output alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_ch.cmd != CMD_PROCESS)) |=> !$rose(out_valid_reg))
        else $error("result raised by a non-process command");

endmodule

`default_nettype wire
